>>> hw/rtl/assert_macros.svh
// assertion macros for the relay overcurrent guard
// used at the end of the top level; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ROG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ROG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rog_pkg.sv
// shared types, codes and constants of the relay overcurrent guard
// no dependencies; used by every module of the block
package rog_pkg;

  localparam int unsigned MAX_PORTS     = 4;
  localparam int unsigned PORTS_DEFAULT = 4;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam int unsigned CUR_W     = 12;
  localparam int unsigned HOLD_W    = 8;
  localparam int unsigned SILENCE_W = 11;
  localparam int unsigned ON_W      = 16;
  localparam int unsigned PORT_W    = 4;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CUR_W-1:0]     THRESHOLD_RESET = 12'd3908;
  localparam logic [HOLD_W-1:0]    HOLD_RESET      = 8'd20;
  localparam logic [SILENCE_W-1:0] TIMEOUT_RESET   = 11'd50;
  localparam logic [ON_W-1:0]      MAX_ON_RESET    = 16'd36000;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_HEARTBEAT = 2'd1,
    CMD_ALL_OFF   = 2'd2,
    CMD_SET_RELAY = 2'd3
  } rog_cmd_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_HOLD      = 2'd1,
    REG_TIMEOUT   = 2'd2,
    REG_MAX_ON    = 2'd3
  } rog_reg_t;

  typedef enum logic [2:0] {
    KIND_TICK_SKIP  = 3'd0,
    KIND_TICK_CHECK = 3'd1,
    KIND_HEARTBEAT  = 3'd2,
    KIND_ALL_OFF    = 3'd3,
    KIND_SET        = 3'd4
  } rog_kind_t;

  typedef struct packed {
    rog_cmd_t          command;
    logic [PORT_W-1:0] port;
    logic              turn_on;
    logic              sample_valid;
    logic [CUR_W-1:0]  current_1;
    logic [CUR_W-1:0]  current_2;
    logic [CUR_W-1:0]  current_3;
    logic [CUR_W-1:0]  current_4;
  } rog_in_t;

  typedef struct packed {
    logic [MAX_PORTS-1:0] relay_mask;
    logic [MAX_PORTS-1:0] trip_mask;
    logic                 link_up;
  } rog_out_t;

  // classified request handed from front to back
  typedef struct packed {
    rog_kind_t            kind;
    logic [IDX_W-1:0]     port_idx;
    logic                 turn_on;
    logic [MAX_PORTS-1:0] over;
  } rog_op_t;

  typedef struct packed {
    logic [CUR_W-1:0]     threshold;
    logic [HOLD_W-1:0]    hold;
    logic [SILENCE_W-1:0] timeout;
    logic [ON_W-1:0]      max_on;
  } rog_cfg_t;

endpackage

>>> hw/rtl/rog_fifo.sv
// small first-word-fall-through queue of registers
// depends on rog_pkg for the default depth
module rog_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = rog_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/rog_front.sv
// front end: classifies each request and compares currents with the threshold
// depends on rog_pkg
module rog_front #(
  parameter int unsigned PORTS = rog_pkg::PORTS_DEFAULT
) (
  input  rog_pkg::rog_in_t                in_req,
  input  logic [rog_pkg::CUR_W-1:0]       threshold,
  output rog_pkg::rog_op_t                op
);

  logic port_ok;

  assign port_ok = (in_req.port != '0) &&
                   (in_req.port <= rog_pkg::PORT_W'(PORTS));

  always_comb begin
    op.port_idx = rog_pkg::IDX_W'(in_req.port - 1'b1);
    op.turn_on  = in_req.turn_on;
    op.over[0]  = (in_req.current_1 >= threshold);
    op.over[1]  = (in_req.current_2 >= threshold);
    op.over[2]  = (in_req.current_3 >= threshold);
    op.over[3]  = (in_req.current_4 >= threshold);
    case (in_req.command)
      rog_pkg::CMD_TICK: begin
        op.kind = in_req.sample_valid ? rog_pkg::KIND_TICK_CHECK : rog_pkg::KIND_TICK_SKIP;
      end
      rog_pkg::CMD_HEARTBEAT: begin
        op.kind = rog_pkg::KIND_HEARTBEAT;
      end
      rog_pkg::CMD_ALL_OFF: begin
        op.kind = rog_pkg::KIND_ALL_OFF;
      end
      rog_pkg::CMD_SET_RELAY: begin
        // out-of-range port only refreshes the watchdog
        op.kind = port_ok ? rog_pkg::KIND_SET : rog_pkg::KIND_HEARTBEAT;
      end
      default: begin
        op.kind = rog_pkg::KIND_HEARTBEAT;
      end
    endcase
  end

endmodule

>>> hw/rtl/rog_back.sv
// back end: relay, trip, overload and watchdog state, one request per cycle while the result queue is not full
// depends on rog_pkg
module rog_back #(
  parameter int unsigned PORTS = rog_pkg::PORTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_valid,
  input  rog_pkg::rog_op_t  op,
  output logic              op_take,
  input  rog_pkg::rog_cfg_t cfg,
  output logic              res_push,
  output rog_pkg::rog_out_t res,
  input  logic              res_full
);

  logic [PORTS-1:0]                 closed_r, closed_nxt;
  logic [PORTS-1:0]                 trip_r, trip_nxt;
  logic [rog_pkg::HOLD_W-1:0]       ovl_r [PORTS];
  logic [rog_pkg::HOLD_W-1:0]       ovl_nxt [PORTS];
  logic [rog_pkg::HOLD_W-1:0]       ovl_inc [PORTS];
  logic [rog_pkg::ON_W-1:0]         ct_r [PORTS];
  logic [rog_pkg::ON_W-1:0]         ct_nxt [PORTS];
  logic [rog_pkg::ON_W-1:0]         ct_inc [PORTS];
  logic [rog_pkg::SILENCE_W-1:0]    sil_r, sil_nxt, sil_inc;
  logic                             link_r, link_nxt;

  assign op_take  = op_valid && !res_full;
  assign res_push = op_take && (op.kind == rog_pkg::KIND_TICK_CHECK);

  // saturating increments
  always_comb begin
    sil_inc = (sil_r == '1) ? sil_r : sil_r + 1'b1;
    for (int p = 0; p < PORTS; p++) begin
      ovl_inc[p] = (ovl_r[p] == '1) ? ovl_r[p] : ovl_r[p] + 1'b1;
      ct_inc[p]  = (ct_r[p] == '1) ? ct_r[p] : ct_r[p] + 1'b1;
    end
  end

  always_comb begin
    closed_nxt = closed_r;
    trip_nxt   = trip_r;
    sil_nxt    = sil_r;
    link_nxt   = link_r;
    for (int p = 0; p < PORTS; p++) begin
      ovl_nxt[p] = ovl_r[p];
      ct_nxt[p]  = ct_r[p];
    end
    if (op_take) begin
      case (op.kind)
        rog_pkg::KIND_TICK_SKIP, rog_pkg::KIND_TICK_CHECK: begin
          sil_nxt = sil_inc;
          for (int p = 0; p < PORTS; p++) begin
            if (closed_r[p]) begin
              ct_nxt[p] = ct_inc[p];
            end
          end
          if (op.kind == rog_pkg::KIND_TICK_CHECK) begin
            for (int p = 0; p < PORTS; p++) begin
              if (!closed_r[p] || !op.over[p]) begin
                ovl_nxt[p] = '0;
              end else if (ovl_inc[p] >= cfg.hold) begin
                closed_nxt[p] = 1'b0;
                trip_nxt[p]   = 1'b1;
                ovl_nxt[p]    = '0;
                ct_nxt[p]     = '0;
              end else begin
                ovl_nxt[p] = ovl_inc[p];
              end
              if (closed_nxt[p] && (ct_nxt[p] > cfg.max_on)) begin
                closed_nxt[p] = 1'b0;
                ct_nxt[p]     = '0;
              end
            end
            if (link_r && (sil_nxt > cfg.timeout)) begin
              link_nxt   = 1'b0;
              closed_nxt = '0;
              for (int p = 0; p < PORTS; p++) begin
                ct_nxt[p] = '0;
              end
            end
          end
        end
        rog_pkg::KIND_HEARTBEAT: begin
          link_nxt = 1'b1;
          sil_nxt  = '0;
        end
        rog_pkg::KIND_ALL_OFF: begin
          link_nxt   = 1'b1;
          sil_nxt    = '0;
          closed_nxt = '0;
          for (int p = 0; p < PORTS; p++) begin
            ct_nxt[p] = '0;
          end
        end
        rog_pkg::KIND_SET: begin
          link_nxt = 1'b1;
          sil_nxt  = '0;
          for (int p = 0; p < PORTS; p++) begin
            // closing a tripped port is refused
            if ((op.port_idx == rog_pkg::IDX_W'(p)) && !(op.turn_on && trip_r[p])) begin
              if (!op.turn_on) begin
                trip_nxt[p] = 1'b0;
              end
              closed_nxt[p] = op.turn_on;
              ct_nxt[p]     = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r <= '0;
      trip_r   <= '0;
      sil_r    <= '0;
      link_r   <= 1'b0;
      for (int p = 0; p < PORTS; p++) begin
        ovl_r[p] <= '0;
        ct_r[p]  <= '0;
      end
    end else begin
      closed_r <= closed_nxt;
      trip_r   <= trip_nxt;
      sil_r    <= sil_nxt;
      link_r   <= link_nxt;
      for (int p = 0; p < PORTS; p++) begin
        ovl_r[p] <= ovl_nxt[p];
        ct_r[p]  <= ct_nxt[p];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < rog_pkg::MAX_PORTS; g++) begin : g_mask
      if (g < PORTS) begin : g_used
        assign res.relay_mask[g] = closed_nxt[g];
        assign res.trip_mask[g]  = trip_nxt[g];
      end else begin : g_unused
        assign res.relay_mask[g] = 1'b0;
        assign res.trip_mask[g]  = 1'b0;
      end
    end
  endgenerate

  assign res.link_up = link_nxt;

endmodule

>>> hw/rtl/relay_overcurrent_guard.sv
// a sample tick's result passes from the request queue through the back end into the result queue
// throughput: one request per cycle while the result queue is not full, set by the back end
// a request is taken whenever the two-entry request queue is not full
// reset: synchronous rst_n clears queues, relays, trip latches, counters and link state
// configuration registers return to their defaults on reset; cfg_ready is always high
// top level: config registers, front end, request queue, back end and result queue
module relay_overcurrent_guard #(
  parameter int unsigned PORTS       = rog_pkg::PORTS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = rog_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  rog_pkg::rog_in_t                 in_data,
  output logic                             out_empty,
  input  logic                             out_pop,
  output rog_pkg::rog_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rog_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rog_pkg::rog_cfg_t cfg_r, cfg_nxt;
  rog_pkg::rog_op_t  front_op;
  rog_pkg::rog_op_t  mid_op;
  rog_pkg::rog_out_t res;
  logic              mid_empty;
  logic              op_take;
  logic              res_push;
  logic              res_full;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (rog_pkg::rog_reg_t'(cfg_index))
        rog_pkg::REG_THRESHOLD: cfg_nxt.threshold = cfg_data[rog_pkg::CUR_W-1:0];
        rog_pkg::REG_HOLD:      cfg_nxt.hold      = cfg_data[rog_pkg::HOLD_W-1:0];
        rog_pkg::REG_TIMEOUT:   cfg_nxt.timeout   = cfg_data[rog_pkg::SILENCE_W-1:0];
        rog_pkg::REG_MAX_ON:    cfg_nxt.max_on    = cfg_data[rog_pkg::ON_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= rog_pkg::THRESHOLD_RESET;
      cfg_r.hold      <= rog_pkg::HOLD_RESET;
      cfg_r.timeout   <= rog_pkg::TIMEOUT_RESET;
      cfg_r.max_on    <= rog_pkg::MAX_ON_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rog_front #(.PORTS(PORTS)) u_front (
    .in_req    (in_data),
    .threshold (cfg_r.threshold),
    .op        (front_op)
  );

  rog_fifo #(.WIDTH($bits(rog_pkg::rog_op_t)), .DEPTH(QUEUE_DEPTH)) u_req_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (front_op),
    .full    (in_full),
    .pop     (op_take),
    .rd_data (mid_op),
    .empty   (mid_empty)
  );

  rog_back #(.PORTS(PORTS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (!mid_empty),
    .op       (mid_op),
    .op_take  (op_take),
    .cfg      (cfg_r),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  rog_fifo #(.WIDTH($bits(rog_pkg::rog_out_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_data),
    .empty   (out_empty)
  );

`include "assert_macros.svh"

  `ROG_ASSERT_IMPLIES(a_trip_opens, clk, rst_n, !out_empty, (out_data.relay_mask & out_data.trip_mask) == 4'b0, "tripped port reported closed")
  `ROG_ASSERT_IMPLIES(a_link_down_open, clk, rst_n, !out_empty && !out_data.link_up, out_data.relay_mask == 4'b0, "relay closed while link down")
  `ROG_ASSERT_IMPLIES(a_unused_ports, clk, rst_n, !out_empty, ((out_data.relay_mask | out_data.trip_mask) >> PORTS) == 4'b0, "unused port bit set")
  `ROG_ASSERT_NEXT(a_req_queued, clk, rst_n, in_push && !in_full, !mid_empty, "accepted request lost")

endmodule
